// ===== rtl/base58_decoder_core_defines.svh =====
// Assertion macros shared by the decoder modules.
`ifndef BASE58_DECODER_CORE_DEFINES_SVH
`define BASE58_DECODER_CORE_DEFINES_SVH
// Assert that a condition implies a consequence on the same clock edge.
`define B58_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert that a condition implies a consequence on the next clock edge.
`define B58_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== rtl/b58dec_pkg.sv =====
package b58dec_pkg;

    localparam int unsigned MAX_BYTES_DEF = 64;
    localparam int unsigned ACC_DEPTH = 64;
    localparam int unsigned ACC_AW = 6;
    localparam int unsigned LEN_W = 7;
    localparam int unsigned CMDQ_DEPTH = 4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BAD   = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_ONES,
        PH_DIGITS,
        PH_TRAIL
    } t_phase;

    typedef enum logic [1:0] {
        CMD_ONE,
        CMD_DIGIT,
        CMD_BAD,
        CMD_END
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [5:0] digit;
    } t_cmd;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_MUL,
        BS_CARRY,
        BS_EMIT_ZERO,
        BS_EMIT_READ,
        BS_EMIT_MAG,
        BS_EMIT_STAT,
        BS_CLEAR
    } t_back_state;

    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [6:0] d;
        d = 7'h7f;
        if (c inside {[8'h31:8'h39]}) d = 7'(c - 8'h31);
        else if (c inside {[8'h41:8'h48]}) d = 7'(c - 8'h41 + 8'd9);
        else if (c inside {[8'h4a:8'h4e]}) d = 7'(c - 8'h4a + 8'd17);
        else if (c inside {[8'h50:8'h5a]}) d = 7'(c - 8'h50 + 8'd22);
        else if (c inside {[8'h61:8'h6b]}) d = 7'(c - 8'h61 + 8'd33);
        else if (c inside {[8'h6d:8'h7a]}) d = 7'(c - 8'h6d + 8'd44);
        return d;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0d]};
    endfunction

endpackage

// ===== rtl/base58_decoder_core.sv =====
// Base58 decoder: one character per push transaction, a zero byte ends the string. Input
// transactions are accepted while the four-entry command queue has room. In the back end a
// base58 digit is dequeued, then a multiply-by-58 pass runs over the accumulator memory (over
// mlen bytes, where mlen is the current magnitude length in bytes), then the carry is written;
// a leading '1' or a bad character is only dequeued and recorded, and whitespace produces no
// command. The terminator is dequeued, then each leading zero byte is emitted, then each
// magnitude byte (memory read then result register), or else a status result, and finally
// the state is cleared. A result waiting on pop stalls the back end.
module base58_decoder_core
    import b58dec_pkg::*;
#(
    parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_text_char,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_status,
    output logic       o_last
);

    logic w_cv, w_qr, w_qv, w_qpop;
    t_cmd w_c, w_qc;

    b58dec_front u_front (
        .i_clk, .i_rst_n, .i_push(push), .i_text_char, .o_full(full),
        .o_cmd_valid(w_cv), .o_cmd(w_c), .i_cmd_ready(w_qr)
    );

    b58dec_cmdq u_q (
        .i_clk, .i_rst_n, .i_wr(w_cv), .i_wdata(w_c), .o_ready(w_qr),
        .o_valid(w_qv), .o_rdata(w_qc), .i_rd(w_qpop)
    );

    b58dec_back #(.MAX_BYTES(MAX_BYTES)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(w_qv), .i_cmd(w_qc), .o_cmd_pop(w_qpop),
        .o_empty(empty), .o_data_byte, .o_status, .o_last, .i_pop(pop)
    );

endmodule

// ===== rtl/b58dec_front.sv =====
`include "base58_decoder_core_defines.svh"
module b58dec_front
    import b58dec_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_text_char,
    output logic       o_full,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd,
    input  logic       i_cmd_ready
);

    t_phase     r_phase, n_phase;
    logic       r_bad, n_bad;
    logic       r_busy, n_busy;
    logic [6:0] w_d;
    logic       w_sp;
    logic       w_acc;

    assign w_d   = digit_of(i_text_char);
    assign w_sp  = is_space(i_text_char);
    assign o_full = !i_cmd_ready || r_busy;
    assign w_acc = i_push && !o_full;

    always_comb begin
        n_phase     = r_phase;
        n_bad       = r_bad;
        n_busy      = r_busy;
        o_cmd_valid = 1'b0;
        o_cmd.op    = CMD_END;
        o_cmd.digit = w_d[5:0];
        if (w_acc) begin
            if (i_text_char == 8'h00) begin
                o_cmd_valid = 1'b1;
                o_cmd.op = CMD_END;
                n_phase = PH_SKIP;
                n_bad = 1'b0;
            end else if (!r_bad) begin
                case (r_phase)
                    PH_SKIP, PH_ONES: begin
                        if (w_d == 7'd0) begin
                            n_phase = PH_ONES;
                            o_cmd_valid = 1'b1;
                            o_cmd.op = CMD_ONE;
                        end else if (w_d != 7'h7f) begin
                            n_phase = PH_DIGITS;
                            o_cmd_valid = 1'b1;
                            o_cmd.op = CMD_DIGIT;
                        end else if (w_sp) begin
                            if (r_phase == PH_ONES) n_phase = PH_TRAIL;
                        end else begin
                            n_bad = 1'b1;
                            o_cmd_valid = 1'b1;
                            o_cmd.op = CMD_BAD;
                        end
                    end
                    PH_DIGITS: begin
                        if (w_d != 7'h7f) begin
                            o_cmd_valid = 1'b1;
                            o_cmd.op = CMD_DIGIT;
                        end else if (w_sp) begin
                            n_phase = PH_TRAIL;
                        end else begin
                            n_bad = 1'b1;
                            o_cmd_valid = 1'b1;
                            o_cmd.op = CMD_BAD;
                        end
                    end
                    default: begin
                        if (!w_sp) begin
                            n_bad = 1'b1;
                            o_cmd_valid = 1'b1;
                            o_cmd.op = CMD_BAD;
                        end
                    end
                endcase
            end
        end
        n_busy = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SKIP;
            r_bad   <= 1'b0;
            r_busy  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bad   <= n_bad;
            r_busy  <= n_busy;
        end
    end

    `B58_ASSERT_IMPL(a_cmd_only_on_accept, i_clk, i_rst_n, o_cmd_valid, w_acc,
        "Command issued without an accepted transaction.")
    `B58_ASSERT_NEXT(a_end_resets_phase, i_clk, i_rst_n,
        w_acc && i_text_char == 8'h00, r_phase == PH_SKIP && !r_bad,
        "Terminator did not reset the parser.")
    `B58_ASSERT_IMPL(a_no_cmd_after_bad, i_clk, i_rst_n,
        r_bad && o_cmd_valid, o_cmd.op == CMD_END,
        "Command issued after a bad character.")

endmodule

// ===== rtl/b58dec_cmdq.sv =====
module b58dec_cmdq
    import b58dec_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_cmd i_wdata,
    output logic o_ready,
    output logic o_valid,
    output t_cmd o_rdata,
    input  logic i_rd
);

    localparam int unsigned AW = $clog2(CMDQ_DEPTH);

    t_cmd          r_mem [CMDQ_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          w_wr, w_rd;

    assign o_ready = r_cnt != (AW+1)'(CMDQ_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_rdata = r_mem[r_rp];
    assign w_wr = i_wr && o_ready;
    assign w_rd = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) r_wp <= r_wp + 1'b1;
            if (w_rd) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_wr) - (AW+1)'(w_rd);
        end
    end

endmodule

// ===== rtl/b58dec_back.sv =====
`include "base58_decoder_core_defines.svh"
module b58dec_back
    import b58dec_pkg::*;
#(
    parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_cmd_pop,
    output logic       o_empty,
    output logic [7:0] o_data_byte,
    output logic [1:0] o_status,
    output logic       o_last,
    input  logic       i_pop
);

    logic [7:0]        r_acc [ACC_DEPTH];
    t_back_state       r_st, n_st;
    logic [LEN_W-1:0]  r_mlen, n_mlen;
    logic [LEN_W-1:0]  r_ones, n_ones;
    logic [1:0]        r_fault, n_fault;
    logic [LEN_W-1:0]  r_idx, n_idx;
    logic [7:0]        r_carry, n_carry;
    logic [7:0]        r_rd;
    logic              r_ov, n_ov;
    logic [7:0]        r_ob, n_ob;
    logic [1:0]        r_os, n_os;
    logic              r_ol, n_ol;
    logic              w_we;
    logic [ACC_AW-1:0] w_wa;
    logic [7:0]        w_wd;
    logic [ACC_AW-1:0] w_ra;
    logic [13:0]       w_prod;
    logic              w_room;
    logic              w_oslot;

    assign w_prod = 14'(r_rd) * 14'd58 + 14'(r_carry);
    assign w_room = ({1'b0, r_mlen} + {1'b0, r_ones}) < (LEN_W+1)'(MAX_BYTES);
    assign w_oslot = !r_ov || i_pop;
    assign o_empty = !r_ov;
    assign o_data_byte = r_ob;
    assign o_status = r_os;
    assign o_last = r_ol;

    always_ff @(posedge i_clk) begin
        if (w_we) r_acc[w_wa] <= w_wd;
        r_rd <= r_acc[w_ra];
    end

    always_comb begin
        n_st = r_st; n_mlen = r_mlen; n_ones = r_ones; n_fault = r_fault;
        n_idx = r_idx; n_carry = r_carry;
        n_ov = r_ov && !i_pop; n_ob = r_ob; n_os = r_os; n_ol = r_ol;
        o_cmd_pop = 1'b0; w_we = 1'b0; w_wa = r_idx[ACC_AW-1:0]; w_wd = '0;
        w_ra = r_idx[ACC_AW-1:0];
        case (r_st)
            BS_IDLE: begin
                w_ra = '0;
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op)
                        CMD_ONE: begin
                            if (r_fault == ST_OK) begin
                                if (w_room) n_ones = r_ones + 1'b1;
                                else n_fault = ST_OVF;
                            end
                        end
                        CMD_DIGIT: begin
                            if (r_fault == ST_OK) begin
                                n_carry = {2'b0, i_cmd.digit};
                                n_idx = '0;
                                n_st = (r_mlen == '0) ? BS_CARRY : BS_MUL;
                            end
                        end
                        CMD_BAD: n_fault = ST_BAD;
                        default: begin
                            n_idx = '0;
                            if (r_fault != ST_OK) n_st = BS_EMIT_STAT;
                            else if (r_ones == '0 && r_mlen == '0) n_st = BS_EMIT_STAT;
                            else if (r_ones != '0) n_st = BS_EMIT_ZERO;
                            else begin
                                n_idx = r_mlen - 1'b1;
                                n_st = BS_EMIT_READ;
                            end
                        end
                    endcase
                end
            end
            BS_MUL: begin
                w_we = 1'b1;
                w_wd = w_prod[7:0];
                n_carry = {2'b0, w_prod[13:8]};
                n_idx = r_idx + 1'b1;
                w_ra = n_idx[ACC_AW-1:0];
                if (n_idx == r_mlen) n_st = BS_CARRY;
            end
            BS_CARRY: begin
                w_ra = '0;
                if (r_carry == '0) n_st = BS_IDLE;
                else if (!w_room) begin
                    n_fault = ST_OVF;
                    n_st = BS_IDLE;
                end else begin
                    w_we = 1'b1;
                    w_wa = r_mlen[ACC_AW-1:0];
                    w_wd = r_carry;
                    n_mlen = r_mlen + 1'b1;
                    n_carry = '0;
                end
            end
            BS_EMIT_ZERO: begin
                if (w_oslot) begin
                    n_ov = 1'b1; n_ob = '0; n_os = ST_OK;
                    n_idx = r_idx + 1'b1;
                    n_ol = (n_idx == r_ones) && (r_mlen == '0);
                    if (n_idx == r_ones) begin
                        if (r_mlen == '0) n_st = BS_CLEAR;
                        else begin
                            n_idx = r_mlen - 1'b1;
                            n_st = BS_EMIT_READ;
                        end
                    end
                end
            end
            BS_EMIT_READ: n_st = BS_EMIT_MAG;
            BS_EMIT_MAG: begin
                if (w_oslot) begin
                    n_ov = 1'b1; n_ob = r_rd; n_os = ST_OK;
                    n_ol = (r_idx == '0);
                    if (r_idx == '0) n_st = BS_CLEAR;
                    else begin
                        n_idx = r_idx - 1'b1;
                        n_st = BS_EMIT_READ;
                    end
                end
            end
            BS_EMIT_STAT: begin
                if (w_oslot) begin
                    n_ov = 1'b1; n_ob = '0; n_ol = 1'b1;
                    n_os = (r_fault != ST_OK) ? r_fault : ST_EMPTY;
                    n_st = BS_CLEAR;
                end
            end
            default: begin
                n_mlen = '0; n_ones = '0; n_fault = ST_OK; n_st = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= BS_IDLE; r_mlen <= '0; r_ones <= '0; r_fault <= ST_OK;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st; r_mlen <= n_mlen; r_ones <= n_ones; r_fault <= n_fault;
            r_ov <= n_ov;
        end
        r_idx <= n_idx; r_carry <= n_carry; r_ob <= n_ob; r_os <= n_os; r_ol <= n_ol;
    end

    `B58_ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, 1'b1,
        ({1'b0, r_mlen} + {1'b0, r_ones}) <= (LEN_W+1)'(MAX_BYTES),
        "Result length exceeds the configured maximum.")
    `B58_ASSERT_IMPL(a_pop_idle, i_clk, i_rst_n, o_cmd_pop, r_st == BS_IDLE,
        "Command taken while busy.")
    `B58_ASSERT_IMPL(a_status_zero, i_clk, i_rst_n, !o_empty && o_status != ST_OK,
        o_data_byte == '0 && o_last, "Status result is malformed.")

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import b58dec_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data_byte;
        logic [1:0] status;
        logic       last;
    } t_result;

    typedef struct {
        string      text;
        bit         typed;
        logic [7:0] data_byte;
        logic [1:0] status;
    } t_vector;

    localparam string ALPHABET =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
    localparam string SPACES = " \t\n\v\f\r";
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int N_RANDOM = 8;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_text_char;
    logic       empty;
    logic       pop;
    logic [7:0] o_data_byte;
    logic [1:0] o_status;
    logic       o_last;

    base58_decoder_core u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_text_char(i_text_char),
        .empty      (empty),
        .pop        (pop),
        .o_data_byte(o_data_byte),
        .o_status   (o_status),
        .o_last     (o_last)
    );

    t_result    decoded_q[$];
    logic [7:0] mag[ACC_DEPTH];
    int         mag_len;
    int         zero_count;
    t_phase     parse_phase;
    logic [1:0] fault;

    int errors;
    int idle_cycles;
    bit hold_req;
    bit quiet;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int digit_value(logic [7:0] c);
        for (int i = 0; i < 58; i++) begin
            if (ALPHABET[i] == c) begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic bit white(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
    endfunction

    function automatic void queue_result(logic [7:0] b, logic [1:0] s, logic l);
        t_result r;
        r = '{b, s, l};
        decoded_q.insert(decoded_q.size(), r);
    endfunction

    function automatic void clear_decoder();
        foreach (mag[i]) mag[i] = 8'h00;
        mag_len = 0;
        zero_count = 0;
        parse_phase = PH_SKIP;
        fault = ST_OK;
    endfunction

    function automatic void add_digit(int d);
        int carry;
        int t;
        carry = d;
        if (fault != ST_OK) begin
            return;
        end
        for (int i = 0; i < mag_len; i++) begin
            t = mag[i] * 58 + carry;
            mag[i] = t[7:0];
            carry = t >> 8;
        end
        while (carry != 0) begin
            if (mag_len + zero_count >= MAX_BYTES_DEF || mag_len >= ACC_DEPTH) begin
                fault = ST_OVF;
                return;
            end
            mag[mag_len] = carry[7:0];
            mag_len++;
            carry = carry >> 8;
        end
    endfunction

    function automatic void add_one();
        if (fault != ST_OK) begin
            return;
        end
        if (zero_count + mag_len >= MAX_BYTES_DEF) begin
            fault = ST_OVF;
        end else begin
            zero_count++;
        end
    endfunction

    function automatic void decode_char(logic [7:0] c);
        int d;
        if (c == 8'h00) begin
            if (fault != ST_OK) begin
                queue_result(8'h00, fault, 1'b1);
            end else if (zero_count + mag_len == 0) begin
                queue_result(8'h00, ST_EMPTY, 1'b1);
            end else begin
                for (int i = 0; i < zero_count; i++) begin
                    queue_result(8'h00, ST_OK, 1'b0);
                end
                for (int i = mag_len; i > 0; i--) begin
                    queue_result(mag[i - 1], ST_OK, 1'b0);
                end
                decoded_q[$].last = 1'b1;
            end
            clear_decoder();
            return;
        end
        if (fault == ST_BAD) begin
            return;
        end
        d = digit_value(c);
        case (parse_phase)
            PH_SKIP, PH_ONES: begin
                if (d == 0) begin
                    parse_phase = PH_ONES;
                    add_one();
                end else if (d > 0) begin
                    parse_phase = PH_DIGITS;
                    add_digit(d);
                end else if (white(c)) begin
                    if (parse_phase == PH_ONES) parse_phase = PH_TRAIL;
                end else begin
                    fault = ST_BAD;
                end
            end
            PH_DIGITS: begin
                if (d >= 0) add_digit(d);
                else if (white(c)) parse_phase = PH_TRAIL;
                else fault = ST_BAD;
            end
            default: begin
                if (!white(c)) fault = ST_BAD;
            end
        endcase
    endfunction

    task automatic send_char(logic [7:0] c);
        int gap;
        push <= 1'b1;
        i_text_char <= c;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        decode_char(c);
        gap = (!quiet && $urandom_range(99) < 24) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_string(t_vector v);
        for (int i = 0; i < v.text.len(); i++) begin
            send_char(v.text[i]);
        end
        send_char(8'h00);
        if (v.typed) begin
            decoded_q[$] = '{v.data_byte, v.status, 1'b1};
        end
    endtask

    function automatic string repeat_char(byte c, int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++) s = {s, string'(c)};
        return s;
    endfunction

    function automatic string random_text();
        string s;
        int kind;
        kind = $urandom_range(99);
        s = "";
        if (kind < 15) begin
            repeat ($urandom_range(1, 3)) s = {s, string'(byte'($urandom_range(1, 255)))};
        end else begin
            repeat ($urandom_range(0, 1)) s = {s, string'(SPACES[$urandom_range(5)])};
            repeat ($urandom_range(0, 2)) s = {s, "1"};
            repeat ($urandom_range(0, 6)) s = {s, string'(ALPHABET[$urandom_range(57)])};
            repeat ($urandom_range(0, 1)) s = {s, string'(SPACES[$urandom_range(5)])};
            if (kind < 25) begin
                s = {s, string'(byte'($urandom_range(1, 255)))};
            end
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected result byte=%0h status=%0d last=%0b",
                    $time, o_data_byte, o_status, o_last);
                errors++;
            end else begin
                t_result e;
                e = decoded_q.pop_front();
                if (o_data_byte !== e.data_byte || o_status !== e.status ||
                    o_last !== e.last) begin
                    $display({"%0t: mismatch expected byte=%0h status=%0d last=%0b, ",
                        "got byte=%0h status=%0d last=%0b"},
                        $time, e.data_byte, e.status, e.last, o_data_byte, o_status, o_last);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        pop = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                pop <= quiet || $urandom_range(99) >= 24;
            end
        end
    end

    initial begin
        t_vector vectors[$];
        errors = 0;
        idle_cycles = 0;
        hold_req = 1'b0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_text_char = 8'h00;
        clear_decoder();
        vectors = '{
            '{"", 1, 8'h00, ST_EMPTY},
            '{" \t\n\v\f\r", 1, 8'h00, ST_EMPTY},
            '{"1", 1, 8'h00, ST_OK},
            '{"2", 1, 8'h01, ST_OK},
            '{"z", 1, 8'h39, ST_OK},
            '{"!", 1, 8'h00, ST_BAD},
            '{"0", 1, 8'h00, ST_BAD},
            '{"2 3", 1, 8'h00, ST_BAD},
            '{"1 1", 1, 8'h00, ST_BAD},
            '{"z\xff", 1, 8'h00, ST_BAD},
            '{"\x80", 1, 8'h00, ST_BAD},
            '{repeat_char("1", 65), 1, 8'h00, ST_OVF},
            '{"  11StV1DL6CwTryKyV  ", 0, 8'h00, ST_OK},
            '{"\t3yQ\r", 0, 8'h00, ST_OK},
            '{"11", 0, 8'h00, ST_OK},
            '{"21", 0, 8'h00, ST_OK},
            '{"5Hue", 0, 8'h00, ST_OK}
        };
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (vectors[i]) begin
            if (i == 2) hold_req = 1'b1;
            send_string(vectors[i]);
        end
        for (int n = 0; n < N_RANDOM; n++) begin
            t_vector v;
            if (n == 3) begin
                push <= 1'b0;
                wait (decoded_q.size() == 0);
                @(posedge i_clk);
            end
            quiet = (n >= 4 && n < 7);
            v = '{random_text(), 0, 8'h00, ST_OK};
            send_string(v);
        end
        push <= 1'b0;
        wait (decoded_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (errors == 0 && decoded_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
